@@ src/htms_pkg.sv @@
`timescale 1ns / 1ps

package htms_pkg;

  localparam int unsigned SLOTS_DEFAULT = 64;
  localparam logic [31:0] ID_START      = 32'd8000;
  localparam int unsigned SLOT_SHIFT    = 16;
  localparam int unsigned SLOT_FIELD_W  = 16;

  typedef enum logic [1:0] {
    OP_ALLOC = 2'd0,
    OP_MARK  = 2'd1,
    OP_SWEEP = 2'd2,
    OP_RSVD  = 2'd3
  } op_e;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_FULL      = 2'd1,
    ST_NOT_READY = 2'd2,
    ST_IGNORED   = 2'd3
  } status_e;

  typedef enum logic [1:0] {
    S_IDLE,
    S_EXEC,
    S_SWEEP
  } state_e;

  typedef struct packed {
    op_e         operation;
    logic [3:0]  object_type;
    logic [31:0] root_handle;
  } cmd_t;

  typedef struct packed {
    status_e     status;
    logic [31:0] new_handle;
    logic [6:0]  reclaimed_count;
    logic [6:0]  active_count;
  } rsp_t;

  // one slot of the object table
  typedef struct packed {
    logic        in_use;
    logic        marked;
    logic [3:0]  obj_type;
    logic [31:0] handle;
  } entry_t;

  // free list control from the sequencer
  typedef struct packed {
    logic clear;
    logic push;
    logic pop;
  } fl_ctrl_t;

endpackage

@@ src/htms_free_list.sv @@
`timescale 1ns / 1ps

module htms_free_list
  import htms_pkg::*;
#(
  parameter int unsigned SLOTS = SLOTS_DEFAULT
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  fl_ctrl_t                 ctrl_i,
  input  logic [$clog2(SLOTS)-1:0] push_slot_i,
  output logic                     empty_o,
  output logic [$clog2(SLOTS)-1:0] head_slot_o
);

  localparam int unsigned SW = $clog2(SLOTS);
  localparam int unsigned CW = SW + 1;

  logic [CW-1:0] head_q, tail_q;
  logic [SW-1:0] mem_q [SLOTS];
  logic [SW-1:0] rd_q;

  // ascending queue of free slots below the high-water mark
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_q <= '0;
      tail_q <= '0;
    end else if (ctrl_i.clear) begin
      head_q <= '0;
      tail_q <= '0;
    end else begin
      if (ctrl_i.push) begin
        tail_q <= tail_q + CW'(1);
      end
      if (ctrl_i.pop) begin
        head_q <= head_q + CW'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.push) begin
      mem_q[tail_q[SW-1:0]] <= push_slot_i;
    end
    rd_q <= mem_q[head_q[SW-1:0]];
  end

  assign empty_o     = (head_q == tail_q);
  assign head_slot_o = rd_q;

endmodule

@@ src/handle_table_mark_sweep.sv @@
`timescale 1ns / 1ps

// channel      | direction | signals                  | transaction taken when
// -------------+-----------+--------------------------+--------------------------
// command      | in        | cmd_i                    | start high, busy low
// result       | out       | result_o                 | done_o high (one cycle)
// config       | in        | cfg_we_i, cfg_wdata_i    | cfg_we_i high
//
// allocate, mark root, disabled and unused codes: the slot table and free list are read
//   while idle, then modified and written back in the execute state
// sweep: one table read per slot below the high-water mark
// reset: no clearing pass, slots at or above the high-water mark count as free
//   with a zero handle and are never read
// the receiver cannot stall: each result is shown for exactly one cycle

module handle_table_mark_sweep
  import htms_pkg::*;
#(
  parameter int unsigned SLOTS = SLOTS_DEFAULT
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic cfg_we_i,
  input  logic cfg_wdata_i,
  input  logic start,
  input  cmd_t cmd_i,
  output logic busy,
  output logic done_o,
  output rsp_t result_o
);

  localparam int unsigned SW = $clog2(SLOTS);
  localparam int unsigned CW = SW + 1;

  state_e        state_q, state_d;
  logic          en_q;
  cmd_t          cmd_q;
  logic [CW-1:0] hwm_q, hwm_d;        // slots ever written form the prefix below this
  logic [CW-1:0] live_q, live_d;
  logic [31:0]   id_q, id_d;
  logic [CW-1:0] rd_idx_q, rd_idx_d;  // next slot the sweep reads
  logic          pv_q, pv_d;          // sweep read data valid this cycle
  logic [SW-1:0] pidx_q, pidx_d;      // slot that the read data belongs to
  logic [CW-1:0] reclaim_q, reclaim_d;
  rsp_t          rsp_q, rsp_d;
  logic          done_q, done_d;

  // slot table memory
  entry_t        tab_q [SLOTS];
  entry_t        tab_rd_q;
  logic          tab_we;
  logic [SW-1:0] tab_waddr, tab_raddr;
  entry_t        tab_wdata;

  // free list
  fl_ctrl_t      fl_ctrl;
  logic          fl_empty;
  logic [SW-1:0] fl_head;
  logic [SW-1:0] fl_push_slot;

  logic          accept;
  logic [16:0]   root_slot;
  logic          root_in_range;
  logic          mark_hit;
  logic          table_full;
  logic [SW-1:0] alloc_slot;
  logic [31:0]   alloc_handle;
  logic          sweep_free;

  assign accept = start && (state_q == S_IDLE);
  assign busy   = (state_q != S_IDLE);

  htms_free_list #(
    .SLOTS(SLOTS)
  ) u_free_list (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .ctrl_i     (fl_ctrl),
    .push_slot_i(fl_push_slot),
    .empty_o    (fl_empty),
    .head_slot_o(fl_head)
  );

  // table read: root slot straight from the port while idle, scan index while sweeping
  assign tab_raddr = (state_q == S_SWEEP) ? rd_idx_q[SW-1:0]
                                          : cmd_i.root_handle[SLOT_SHIFT +: SW];

  always_ff @(posedge clk_i) begin
    if (tab_we) begin
      tab_q[tab_waddr] <= tab_wdata;
    end
    tab_rd_q <= tab_q[tab_raddr];
  end

  // mark root decode: slots at or above the high-water mark hold a zero handle
  assign root_slot     = 17'(cmd_q.root_handle[SLOT_SHIFT +: SLOT_FIELD_W]);
  assign root_in_range = (root_slot < 17'(hwm_q));
  assign mark_hit      = root_in_range ? (tab_rd_q.handle == cmd_q.root_handle)
                                       : (cmd_q.root_handle == 32'd0);

  // allocate: lowest free slot is the free list head, else the high-water mark
  assign table_full   = fl_empty && (hwm_q == CW'(SLOTS));
  assign alloc_slot   = fl_empty ? hwm_q[SW-1:0] : fl_head;
  assign alloc_handle = id_q | {16'(alloc_slot), 16'd0};

  // sweep: in use and unmarked is reclaimed; any slot not both in use and marked goes on the free list
  assign sweep_free = !(tab_rd_q.in_use && tab_rd_q.marked);

  always_comb begin
    state_d      = state_q;
    hwm_d        = hwm_q;
    live_d       = live_q;
    id_d         = id_q;
    rd_idx_d     = rd_idx_q;
    pv_d         = 1'b0;
    pidx_d       = pidx_q;
    reclaim_d    = reclaim_q;
    done_d       = 1'b0;
    rsp_d        = rsp_q;
    tab_we       = 1'b0;
    tab_waddr    = alloc_slot;
    tab_wdata    = tab_rd_q;
    fl_ctrl      = '0;
    fl_push_slot = pidx_q;

    unique case (state_q)
      S_IDLE: begin
        if (accept) begin
          state_d = S_EXEC;
        end
      end

      S_EXEC: begin
        state_d                = S_IDLE;
        done_d                 = 1'b1;
        rsp_d.status           = ST_OK;
        rsp_d.new_handle       = 32'd0;
        rsp_d.reclaimed_count  = 7'd0;
        rsp_d.active_count     = 7'(live_q);
        if (!en_q) begin
          rsp_d.status = ST_NOT_READY;
        end else begin
          case (cmd_q.operation)
            OP_ALLOC: begin
              if (table_full) begin
                rsp_d.status = ST_FULL;
              end else begin
                tab_we             = 1'b1;
                tab_waddr          = alloc_slot;
                tab_wdata.in_use   = 1'b1;
                tab_wdata.marked   = 1'b0;
                tab_wdata.obj_type = cmd_q.object_type;
                tab_wdata.handle   = alloc_handle;
                fl_ctrl.pop        = !fl_empty;
                if (fl_empty) begin
                  hwm_d = hwm_q + CW'(1);
                end
                id_d                = id_q + 32'd1;
                live_d              = live_q + CW'(1);
                rsp_d.new_handle    = alloc_handle;
                rsp_d.active_count  = 7'(live_q + CW'(1));
              end
            end
            OP_MARK: begin
              if (mark_hit) begin
                // a zero root at or above the high-water mark needs no write
                tab_we           = root_in_range;
                tab_waddr        = cmd_q.root_handle[SLOT_SHIFT +: SW];
                tab_wdata        = tab_rd_q;
                tab_wdata.marked = 1'b1;
              end else begin
                rsp_d.status = ST_IGNORED;
              end
            end
            OP_SWEEP: begin
              state_d       = S_SWEEP;
              done_d        = 1'b0;
              fl_ctrl.clear = 1'b1;
              rd_idx_d      = '0;
              reclaim_d     = '0;
            end
            default: begin
              rsp_d.status = ST_IGNORED;
            end
          endcase
        end
      end

      S_SWEEP: begin
        // read one slot per cycle, write it back the cycle after
        if (rd_idx_q < hwm_q) begin
          pv_d     = 1'b1;
          pidx_d   = rd_idx_q[SW-1:0];
          rd_idx_d = rd_idx_q + CW'(1);
        end
        if (pv_q) begin
          tab_we           = 1'b1;
          tab_waddr        = pidx_q;
          tab_wdata        = tab_rd_q;
          tab_wdata.in_use = tab_rd_q.in_use && tab_rd_q.marked;
          tab_wdata.marked = 1'b0;
          fl_ctrl.push     = sweep_free;
          fl_push_slot     = pidx_q;
          if (tab_rd_q.in_use && !tab_rd_q.marked) begin
            reclaim_d = reclaim_q + CW'(1);
            live_d    = live_q - CW'(1);
          end
        end
        if ((rd_idx_q == hwm_q) && !pv_q) begin
          state_d               = S_IDLE;
          done_d                = 1'b1;
          rsp_d.status          = ST_OK;
          rsp_d.new_handle      = 32'd0;
          rsp_d.reclaimed_count = 7'(reclaim_q);
          rsp_d.active_count    = 7'(live_q);
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      en_q      <= 1'b0;
      hwm_q     <= '0;
      live_q    <= '0;
      id_q      <= ID_START;
      rd_idx_q  <= '0;
      pv_q      <= 1'b0;
      reclaim_q <= '0;
      done_q    <= 1'b0;
    end else begin
      state_q   <= state_d;
      hwm_q     <= hwm_d;
      live_q    <= live_d;
      id_q      <= id_d;
      rd_idx_q  <= rd_idx_d;
      pv_q      <= pv_d;
      reclaim_q <= reclaim_d;
      done_q    <= done_d;
      if (cfg_we_i) begin
        en_q <= cfg_wdata_i;
      end
    end
  end

  // payload registers, no reset
  always_ff @(posedge clk_i) begin
    if (accept) begin
      cmd_q <= cmd_i;
    end
    pidx_q <= pidx_d;
    rsp_q  <= rsp_d;
  end

  assign done_o   = done_q;
  assign result_o = rsp_q;

  // a result is only shown once the sequencer is free again
  a_done_not_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> !busy)
    else $error("result shown while busy");

  // live objects all sit below the high-water mark
  a_live_le_hwm: assert property (@(posedge clk_i) disable iff (!rst_ni)
    live_q <= hwm_q)
    else $error("live count above high-water mark");

  a_hwm_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    hwm_q <= CW'(SLOTS))
    else $error("high-water mark beyond table");

  // single-step operations finish in the cycle after execute
  a_exec_next: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_EXEC) |=> (done_o || (state_q == S_SWEEP)))
    else $error("execute neither finished nor started a sweep");

  // full only when every slot has been used and none is on the free list
  a_full_hwm: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && (result_o.status == ST_FULL)) |-> (hwm_q == CW'(SLOTS)))
    else $error("table full reported with free slots left");

endmodule
